// ===== hw/rtl/csf_pkg.sv =====
// Package for the CORDIC sine unit: fixed-point constants, the arctangent table
// and the data types passed from cell to cell. No dependencies.
`timescale 1ns / 1ps

package csf_pkg;

  localparam int unsigned ANGLE_W   = 32;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned FRAC_BITS = 16;

  // Pi, pi/2 and the gain constant, all at FRAC_BITS fraction bits.
  localparam logic [63:0] PI_FIX   = 64'd205887;
  localparam logic [63:0] HALF_PI  = PI_FIX >> 1;
  localparam logic [63:0] MOD_2PI  = PI_FIX << 1;
  localparam logic [63:0] GAIN_FIX = 64'd39797;

  // Number of compare-subtract steps that reduce a full-range angle modulo 2*pi.
  localparam int unsigned MOD_STEPS = 14;

  typedef logic [ANGLE_W-1:0]       angle_t;
  typedef logic signed [WORD_W-1:0] word_t;

  localparam angle_t QUAD_BASE_1 = HALF_PI[ANGLE_W-1:0];
  localparam angle_t QUAD_BASE_2 = ANGLE_W'(HALF_PI * 2);
  localparam angle_t QUAD_BASE_3 = ANGLE_W'(HALF_PI * 3);
  localparam angle_t QUAD_BASE_4 = ANGLE_W'(HALF_PI * 4);
  localparam word_t  HALF_PI_W   = HALF_PI[WORD_W-1:0];
  localparam word_t  GAIN_W      = GAIN_FIX[WORD_W-1:0];

  typedef enum logic [1:0] {
    QUAD_0,
    QUAD_1,
    QUAD_2,
    QUAD_3
  } quad_e;

  typedef struct packed {
    word_t x;
    word_t y;
    word_t z;
    quad_e quad;
  } rot_t;

  // Rounded atan(2^-step) at FRAC_BITS fraction bits; it rounds to zero past step 16.
  function automatic word_t atan_val(input int unsigned step);
    case (step)
      0:       return 32'sd51472;
      1:       return 32'sd30386;
      2:       return 32'sd16055;
      3:       return 32'sd8150;
      4:       return 32'sd4091;
      5:       return 32'sd2047;
      6:       return 32'sd1024;
      7:       return 32'sd512;
      8:       return 32'sd256;
      9:       return 32'sd128;
      10:      return 32'sd64;
      11:      return 32'sd32;
      12:      return 32'sd16;
      13:      return 32'sd8;
      14:      return 32'sd4;
      15:      return 32'sd2;
      16:      return 32'sd1;
      default: return '0;
    endcase
  endfunction

endpackage

// ===== hw/rtl/csf_mod_cell.sv =====
// One restoring step of the modulo-2*pi angle reduction: subtracts a shifted
// modulus when the angle is not below it. Depends on csf_pkg.
`timescale 1ns / 1ps

module csf_mod_cell
  import csf_pkg::*;
#(
  parameter int unsigned SHIFT = 0
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  output logic   ready_o,
  input  angle_t data_i,
  output logic   valid_o,
  input  logic   ready_i,
  output angle_t data_o
);

  localparam logic [63:0] SUB_WIDE = MOD_2PI << SHIFT;
  localparam angle_t      SUB      = SUB_WIDE[ANGLE_W-1:0];

  logic   en;
  logic   valid_q;
  angle_t data_q, data_d;

  assign en = !valid_q || ready_i;

  always_comb begin
    data_d = (data_i >= SUB) ? data_i - SUB : data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      data_q <= data_d;
    end
  end

  assign ready_o = en;
  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== hw/rtl/csf_quad_stage.sv =====
// Splits the reduced angle into its quadrant and its residue modulo pi/2 and
// loads the starting CORDIC vector. Depends on csf_pkg.
`timescale 1ns / 1ps

module csf_quad_stage
  import csf_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  output logic   ready_o,
  input  angle_t data_i,
  output logic   valid_o,
  input  logic   ready_i,
  output rot_t   data_o
);

  logic   en;
  logic   valid_q;
  rot_t   data_q, data_d;
  angle_t base;
  angle_t resid;

  assign en = !valid_q || ready_i;

  // A residue of up to one ulp past four quarter turns folds back to quadrant zero.
  always_comb begin
    if (data_i >= QUAD_BASE_4) begin
      base        = QUAD_BASE_4;
      data_d.quad = QUAD_0;
    end else if (data_i >= QUAD_BASE_3) begin
      base        = QUAD_BASE_3;
      data_d.quad = QUAD_3;
    end else if (data_i >= QUAD_BASE_2) begin
      base        = QUAD_BASE_2;
      data_d.quad = QUAD_2;
    end else if (data_i >= QUAD_BASE_1) begin
      base        = QUAD_BASE_1;
      data_d.quad = QUAD_1;
    end else begin
      base        = '0;
      data_d.quad = QUAD_0;
    end
    resid    = data_i - base;
    data_d.x = GAIN_W;
    data_d.y = '0;
    data_d.z = $signed(resid);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      data_q <= data_d;
    end
  end

  assign ready_o = en;
  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== hw/rtl/csf_rot_cell.sv =====
// One rotation-mode CORDIC micro-rotation with a fixed shift and arctangent
// constant. Depends on csf_pkg.
`timescale 1ns / 1ps

module csf_rot_cell
  import csf_pkg::*;
#(
  parameter int unsigned STEP = 0
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  rot_t data_i,
  output logic valid_o,
  input  logic ready_i,
  output rot_t data_o
);

  localparam word_t ATAN = atan_val(STEP);

  logic  en;
  logic  valid_q;
  logic  neg;
  rot_t  data_q, data_d;
  word_t neg_x, neg_y;
  word_t x_sh, y_sh;

  assign en = !valid_q || ready_i;

  always_comb begin
    neg         = data_i.z[WORD_W-1];
    neg_x       = -data_i.x;
    neg_y       = -data_i.y;
    x_sh        = (neg ? neg_x : data_i.x) >>> STEP;
    y_sh        = (neg ? neg_y : data_i.y) >>> STEP;
    data_d.x    = data_i.x - y_sh;
    data_d.y    = data_i.y + x_sh;
    data_d.z    = neg ? data_i.z + ATAN : data_i.z - ATAN;
    data_d.quad = data_i.quad;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      data_q <= data_d;
    end
  end

  assign ready_o = en;
  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== hw/rtl/cordic_sine_fixed_unit.sv =====
// Channel   Dir   tdata                      Meaning
// s_axis    in    angle [31:0] unsigned      angle in radians, 16 fraction bits
// m_axis    out   sine  [31:0] signed        sine of the angle, 16 fraction bits
//
// One item enters per cycle while the output is not held back; the path holds 14 modulo cells,
// one quadrant cell, ITERATIONS rotation cells and the output register.
// Every cell has its own valid flag and loads whenever it is empty or its
// successor loads, so bubbles fill while a result waits at the output.
// Reset clears all valid flags; the data registers are not reset.
// Top level of the CORDIC sine unit; depends on csf_pkg, csf_mod_cell,
// csf_quad_stage and csf_rot_cell.
`timescale 1ns / 1ps

module cordic_sine_fixed_unit
  import csf_pkg::*;
#(
  parameter int unsigned ITERATIONS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] angle
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [31:0] sine
);

  logic   mod_valid [MOD_STEPS+1];
  logic   mod_ready [MOD_STEPS+1];
  angle_t mod_data  [MOD_STEPS+1];

  logic   rot_valid [ITERATIONS+1];
  logic   rot_ready [ITERATIONS+1];
  rot_t   rot_data  [ITERATIONS+1];

  logic   out_en;
  logic   out_valid_q;
  word_t  sine_q, sine_d;

  assign mod_valid[0]  = s_axis_tvalid;
  assign mod_data[0]   = s_axis_tdata;
  assign s_axis_tready = mod_ready[0];

  for (genvar k = 0; k < MOD_STEPS; k++) begin : g_mod
    csf_mod_cell #(
      .SHIFT(MOD_STEPS - 1 - k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(mod_valid[k]),
      .ready_o(mod_ready[k]),
      .data_i (mod_data[k]),
      .valid_o(mod_valid[k+1]),
      .ready_i(mod_ready[k+1]),
      .data_o (mod_data[k+1])
    );
  end

  csf_quad_stage u_quad (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(mod_valid[MOD_STEPS]),
    .ready_o(mod_ready[MOD_STEPS]),
    .data_i (mod_data[MOD_STEPS]),
    .valid_o(rot_valid[0]),
    .ready_i(rot_ready[0]),
    .data_o (rot_data[0])
  );

  for (genvar i = 0; i < ITERATIONS; i++) begin : g_rot
    csf_rot_cell #(
      .STEP(i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(rot_valid[i]),
      .ready_o(rot_ready[i]),
      .data_i (rot_data[i]),
      .valid_o(rot_valid[i+1]),
      .ready_i(rot_ready[i+1]),
      .data_o (rot_data[i+1])
    );
  end

  assign out_en                = !out_valid_q || m_axis_tready;
  assign rot_ready[ITERATIONS] = out_en;

  always_comb begin
    unique case (rot_data[ITERATIONS].quad)
      QUAD_0:  sine_d = rot_data[ITERATIONS].y;
      QUAD_1:  sine_d = rot_data[ITERATIONS].x;
      QUAD_2:  sine_d = -rot_data[ITERATIONS].y;
      QUAD_3:  sine_d = -rot_data[ITERATIONS].x;
      default: sine_d = rot_data[ITERATIONS].y;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_en) begin
      out_valid_q <= rot_valid[ITERATIONS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en) begin
      sine_q <= sine_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = sine_q;

  a_ready_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while the output register is empty");

  a_residue_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rot_valid[0] |-> (rot_data[0].z >= 0) && (rot_data[0].z <= HALF_PI_W))
    else $error("quadrant residue outside one quarter turn");

  a_sine_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata) <= 32'sd66000)
                      && ($signed(m_axis_tdata) >= -32'sd66000))
    else $error("sine result beyond unit magnitude");

endmodule
